// File: rtl/core/dot_pkg.sv
// Shared types, constants and constant tables of the dust opacity pipeline.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package dot_pkg;

    // field widths
    localparam int RAD_W  = 20;
    localparam int DUST_W = 16;
    localparam int OPAC_W = 32;

    // fixed-point layout
    localparam int FRAC_BITS = 16;
    localparam int MANT_W    = 31;  // Q30 mantissa in [1, 2)

    // table geometry
    localparam int RAD_SAMPLES = 15;
    localparam int DUST_ZONES  = 5;
    localparam int COL_W       = $clog2(RAD_SAMPLES);
    localparam int ZONE_W      = $clog2(DUST_ZONES + 1);
    localparam int LK_W        = 23;  // biased log opacity

    // zone upper bounds in 1/16 K: 160, 275, 425, 680, 1500 K
    localparam logic [DUST_W-1:0] ZONE_BOUND [DUST_ZONES] =
        '{16'd2560, 16'd4400, 16'd6800, 16'd10880, 16'd24000};

    // log10 opacity in units of 1e-6
    localparam int LK_TABLE [DUST_ZONES][RAD_SAMPLES] = '{
        '{-1909515, -1501762, -1261021, -1064375, -766179, -248516, 393632,
          718565, 1003537, 1070375, 1185414, 1433439, 1615410, 1833331, 2240292},
        '{-2058471, -1639524, -1393756, -1217712, -1003531, -653798, -144443,
          337815, 620450, 707379, 817127, 1162059, 1477533, 1731472, 2122441},
        '{-2092757, -1668844, -1419798, -1249148, -1052610, -723996, -218976,
          267917, 549875, 638001, 754558, 1120483, 1447717, 1697548, 2066532},
        '{-2466847, -1998309, -1709479, -1545481, -1440340, -1285605, -829712,
          -281519, 4258, 126691, 315188, 826777, 1229619, 1469115, 1695277},
        '{-3744834, -3298657, -2876656, -2499945, -2165803, -1874319, -1558813,
          -1060619, -339659, 536814, 1191554, 1438449, 1479227, 1519792, 1660375}
    };

    localparam int                LOG_BIAS    = 4000000;
    localparam logic [31:0]       LOG10_2_Q32 = 32'd1292913987;
    localparam logic [31:0]       LOG2_10_Q32 = 32'd935039633;
    localparam logic [63:0]       E0_FULL     = 64'd4000000 * 64'd935039633;
    localparam logic [23:0]       EXP_BIAS    = 24'(E0_FULL >> 32);
    localparam logic [23:0]       EXP_OFFSET  = 24'(24 << FRAC_BITS);

    typedef logic [MANT_W-1:0] pow2_rom_t [FRAC_BITS];

    // integer square root, elaboration only
    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] b;
        r = 64'd0;
        x = v;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // factors 2^(2^-(k+1)) in Q30
    function automatic pow2_rom_t pow2_rom_build();
        pow2_rom_t   rom;
        logic [63:0] cur;
        cur = isqrt(64'd2 << 60);
        rom[0] = MANT_W'(cur);
        for (int k = 1; k < FRAC_BITS; k++)
        begin
            cur = isqrt(cur << 30);
            rom[k] = MANT_W'(cur);
        end
        return rom;
    endfunction

    localparam pow2_rom_t POW2_ROM = pow2_rom_build();

    // biased table entry
    function automatic logic [LK_W-1:0] lk_biased(input logic [ZONE_W-1:0] z,
                                                  input logic [COL_W-1:0] c);
        int v;
        v = LK_TABLE[z][c] + LOG_BIAS;
        return LK_W'(v);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/dot_stream_if.sv
// Valid/ready stream interfaces for request and response channels.
// Depends on dot_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dot_req_if;
    import dot_pkg::*;
    logic              valid;
    logic              ready;
    logic [RAD_W-1:0]  rad_temp;
    logic [DUST_W-1:0] dust_temp;
    modport source (output valid, output rad_temp, output dust_temp, input ready);
    modport sink (input valid, input rad_temp, input dust_temp, output ready);
endinterface

interface dot_rsp_if;
    import dot_pkg::*;
    logic              valid;
    logic              ready;
    logic [OPAC_W-1:0] opacity;
    logic              sublimated;
    modport source (output valid, output opacity, output sublimated, input ready);
    modport sink (input valid, input opacity, input sublimated, output ready);
endinterface

`default_nettype wire

// File: rtl/core/dust_opacity_table_interp.sv
// Throughput one item per cycle while the response is not stalled, since every stage,
// including the 16-stage log2 squaring chain and the 16-stage 2^x product chain with
// one 31x31 multiply per stage, takes an item each cycle. A stalled response holds
// the whole pipe.
// Reset clears all valid bits and sets hot_reg to 0; no clear pass.
// Depends on dot_pkg, dot_stream_if, dot_log2, dot_exp2.
`timescale 1ns / 1ps
`default_nettype none

module dust_opacity_table_interp (
    input  wire logic       clk,
    input  wire logic       rst_n,
    dot_req_if.sink         req,
    dot_rsp_if.source       rsp,
    input  wire logic       psel,
    input  wire logic       penable,
    input  wire logic       pwrite,
    input  wire logic [2:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    import dot_pkg::*;

    localparam logic REG_HOT_DUST = 1'b0;
    localparam int   PIPE_DEPTH   = 1 + FRAC_BITS + 7 + FRAC_BITS + 1;
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(RAD_SAMPLES - 1);
    localparam logic [ZONE_W-1:0] LAST_ZONE = ZONE_W'(DUST_ZONES - 1);

    typedef struct packed {
        logic [ZONE_W-1:0] zone;
        logic              subl;
        logic              rzero;
        logic [4:0]        pos;
    } log_side_t;

    typedef struct packed {
        logic       subl;
        logic       neg;
        logic [7:0] shift;
    } exp_side_t;

    // configuration register
    logic hot_reg;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HOT_DUST) ? {31'd0, hot_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hot_reg <= 1'b0;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_HOT_DUST)
            hot_reg <= pwdata[0];
    end

    // global advance
    logic vld_reg [PIPE_DEPTH];
    logic adv;
    assign adv = !vld_reg[PIPE_DEPTH-1] || rsp.ready;
    assign req.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= req.valid;
            for (int i = 1; i < PIPE_DEPTH; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // stage A: zone search, leading one, mantissa normalize
    log_side_t         a_side_next;
    logic [MANT_W-1:0] a_mant_next;
    log_side_t         a_side_reg;
    logic [MANT_W-1:0] a_mant_reg;

    always_comb
    begin
        logic [ZONE_W-1:0] z;
        logic [4:0]        p;
        z = ZONE_W'(DUST_ZONES);
        for (int i = DUST_ZONES - 1; i >= 0; i--)
            if (req.dust_temp < ZONE_BOUND[i])
                z = ZONE_W'(i);
        p = 5'd0;
        for (int i = 0; i < RAD_W; i++)
            if (req.rad_temp[i])
                p = 5'(i);
        a_side_next.subl  = (z == ZONE_W'(DUST_ZONES)) && !hot_reg;
        a_side_next.zone  = (z == ZONE_W'(DUST_ZONES)) ? LAST_ZONE : z;
        a_side_next.rzero = (req.rad_temp == '0);
        a_side_next.pos   = p;
        a_mant_next = {{(MANT_W-RAD_W){1'b0}}, req.rad_temp} << (5'd30 - p);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_side_reg <= a_side_next;
            a_mant_reg <= a_mant_next;
        end
    end

    // log2 fraction pipeline with side data alongside
    logic [FRAC_BITS-1:0] lg_frac;
    log_side_t            ls_reg [FRAC_BITS];

    dot_log2 u_log2 (
        .clk  (clk),
        .en   (adv),
        .mant (a_mant_reg),
        .frac (lg_frac)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ls_reg[0] <= a_side_reg;
            for (int i = 1; i < FRAC_BITS; i++)
                ls_reg[i] <= ls_reg[i-1];
        end
    end

    // stage B: log10 = (log2(rad) - 4) * log10(2), clamped at zero
    logic [19:0]       b_lg_reg;
    logic [ZONE_W-1:0] b_zone_reg;
    logic              b_subl_reg;

    always_ff @(posedge clk)
    begin
        logic [20:0] l2;
        logic [20:0] diff;
        logic [52:0] prod;
        if (adv)
        begin
            l2   = {ls_reg[FRAC_BITS-1].pos, lg_frac};
            diff = (!ls_reg[FRAC_BITS-1].rzero && l2 > 21'(4 << FRAC_BITS))
                   ? l2 - 21'(4 << FRAC_BITS) : 21'd0;
            prod = {32'd0, diff} * {21'd0, LOG10_2_Q32};
            b_lg_reg   <= prod[51:32];
            b_zone_reg <= ls_reg[FRAC_BITS-1].zone;
            b_subl_reg <= ls_reg[FRAC_BITS-1].subl;
        end
    end

    // stage C: column and weight
    logic [COL_W-1:0]     c_col_reg;
    logic [FRAC_BITS-1:0] c_w_reg;
    logic [ZONE_W-1:0]    c_zone_reg;
    logic                 c_subl_reg;

    always_ff @(posedge clk)
    begin
        logic [25:0] s;
        logic [7:0]  col;
        if (adv)
        begin
            s   = {6'd0, b_lg_reg} * 26'(RAD_SAMPLES - 1);
            col = 8'(s[25:18]);
            if (b_lg_reg >= 20'(4 << FRAC_BITS) || col >= 8'(RAD_SAMPLES - 1))
            begin
                c_col_reg <= LAST_COL;
                c_w_reg   <= '0;
            end
            else
            begin
                c_col_reg <= col[COL_W-1:0];
                c_w_reg   <= s[17:2];
            end
            c_zone_reg <= b_zone_reg;
            c_subl_reg <= b_subl_reg;
        end
    end

    // stage D: table read of both neighbors
    logic [LK_W-1:0]      d_ua_reg;
    logic [LK_W-1:0]      d_ub_reg;
    logic [FRAC_BITS-1:0] d_w_reg;
    logic                 d_subl_reg;

    always_ff @(posedge clk)
    begin
        logic [COL_W-1:0] cn;
        if (adv)
        begin
            cn = (c_col_reg < LAST_COL) ? c_col_reg + COL_W'(1) : c_col_reg;
            d_ua_reg   <= lk_biased(c_zone_reg, c_col_reg);
            d_ub_reg   <= lk_biased(c_zone_reg, cn);
            d_w_reg    <= c_w_reg;
            d_subl_reg <= c_subl_reg;
        end
    end

    // stage E: weighted products
    logic [39:0] e_pa_reg;
    logic [39:0] e_pb_reg;
    logic        e_subl_reg;

    always_ff @(posedge clk)
    begin
        logic [16:0] wa;
        if (adv)
        begin
            wa = 17'h10000 - {1'b0, d_w_reg};
            e_pa_reg   <= {17'd0, d_ua_reg} * {23'd0, wa};
            e_pb_reg   <= {17'd0, d_ub_reg} * {24'd0, d_w_reg};
            e_subl_reg <= d_subl_reg;
        end
    end

    // stage F: interpolated value
    logic [LK_W-1:0] f_u_reg;
    logic            f_subl_reg;

    always_ff @(posedge clk)
    begin
        logic [40:0] sum;
        if (adv)
        begin
            sum = {1'b0, e_pa_reg} + {1'b0, e_pb_reg};
            f_u_reg    <= sum[38:16];
            f_subl_reg <= e_subl_reg;
        end
    end

    // stage G: scale to log2 units
    logic [23:0] g_eb_reg;
    logic        g_subl_reg;

    always_ff @(posedge clk)
    begin
        logic [54:0] prod;
        if (adv)
        begin
            prod = {32'd0, f_u_reg} * {23'd0, LOG2_10_Q32};
            g_eb_reg   <= {1'b0, prod[54:32]};
            g_subl_reg <= f_subl_reg;
        end
    end

    // stage H: exponent, split into integer shift and fraction
    exp_side_t            h_side_reg;
    logic [FRAC_BITS-1:0] h_frac_reg;

    always_ff @(posedge clk)
    begin
        logic [23:0] tp;
        logic [23:0] t;
        if (adv)
        begin
            tp = g_eb_reg + EXP_OFFSET;
            t  = tp - EXP_BIAS;
            h_side_reg.neg   <= (tp < EXP_BIAS);
            h_side_reg.shift <= t[23:16];
            h_side_reg.subl  <= g_subl_reg;
            h_frac_reg       <= t[15:0];
        end
    end

    // 2^frac pipeline with side data alongside
    logic [MANT_W-1:0] x_mant;
    exp_side_t         xs_reg [FRAC_BITS];

    dot_exp2 u_exp2 (
        .clk  (clk),
        .en   (adv),
        .frac (h_frac_reg),
        .mant (x_mant)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xs_reg[0] <= h_side_reg;
            for (int i = 1; i < FRAC_BITS; i++)
                xs_reg[i] <= xs_reg[i-1];
        end
    end

    // output stage: shift into Q8.24 and saturate
    logic [OPAC_W-1:0] out_opac_reg;
    logic              out_subl_reg;

    always_ff @(posedge clk)
    begin
        exp_side_t   sd;
        logic [32:0] r;
        if (adv)
        begin
            sd = xs_reg[FRAC_BITS-1];
            if (sd.shift >= 8'd30)
                r = {2'b0, x_mant} << (sd.shift[4:0] - 5'd30);
            else
                r = {2'b0, x_mant} >> (5'd30 - sd.shift[4:0]);
            if (sd.subl || sd.neg)
                out_opac_reg <= '0;
            else if (sd.shift >= 8'd32 || r[32])
                out_opac_reg <= '1;
            else
                out_opac_reg <= r[31:0];
            out_subl_reg <= sd.subl;
        end
    end

    assign rsp.valid      = vld_reg[PIPE_DEPTH-1];
    assign rsp.opacity    = out_opac_reg;
    assign rsp.sublimated = out_subl_reg;

    // sublimated results carry zero opacity
    a_subl_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.sublimated |-> rsp.opacity == '0)
        else $error("sublimated result with nonzero opacity");

    // sublimation only happens with the hot dust mode off
    a_subl_mode: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.sublimated |-> !hot_reg)
        else $error("sublimated result while hot dust uses last zone");

    // a stall freezes the valid bits along the pipe
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg[0]) && $stable(vld_reg[FRAC_BITS])
                 && $stable(vld_reg[PIPE_DEPTH-1]))
        else $error("pipeline moved during stall");

endmodule

`default_nettype wire

// File: rtl/core/dot_log2.sv
// Fractional log2 by repeated squaring of a Q30 mantissa, one square per stage.
// Depends on dot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dot_log2 (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [dot_pkg::MANT_W-1:0] mant,
    output logic [dot_pkg::FRAC_BITS-1:0]   frac
);
    import dot_pkg::*;

    logic [MANT_W-1:0]    m_reg    [FRAC_BITS];
    logic [FRAC_BITS-1:0] frac_reg [FRAC_BITS];
    logic [MANT_W-1:0]    m_next   [FRAC_BITS];
    logic [FRAC_BITS-1:0] frac_next [FRAC_BITS];

    // one squaring per stage; result >= 2 sets the bit and halves
    always_comb
    begin
        logic [2*MANT_W-1:0] sq;
        logic [MANT_W:0]     sh;
        logic [MANT_W-1:0]   m_prev;
        logic [FRAC_BITS-1:0] f_prev;
        for (int j = 0; j < FRAC_BITS; j++)
        begin
            m_prev = (j == 0) ? mant : m_reg[(j == 0) ? 0 : j - 1];
            f_prev = (j == 0) ? '0 : frac_reg[(j == 0) ? 0 : j - 1];
            sq = {{MANT_W{1'b0}}, m_prev} * {{MANT_W{1'b0}}, m_prev};
            sh = sq[2*MANT_W-1:30];
            if (sh[MANT_W])
            begin
                m_next[j]    = sh[MANT_W:1];
                frac_next[j] = f_prev | (FRAC_BITS'(1) << (FRAC_BITS - 1 - j));
            end
            else
            begin
                m_next[j]    = sh[MANT_W-1:0];
                frac_next[j] = f_prev;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < FRAC_BITS; j++)
            begin
                m_reg[j]    <= m_next[j];
                frac_reg[j] <= frac_next[j];
            end
        end
    end

    assign frac = frac_reg[FRAC_BITS-1];

endmodule

`default_nettype wire

// File: rtl/core/dot_exp2.sv
// 2^frac in Q30 as a product of ROM factors, one fraction bit per stage.
// Depends on dot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dot_exp2 (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [dot_pkg::FRAC_BITS-1:0] frac,
    output logic [dot_pkg::MANT_W-1:0]        mant
);
    import dot_pkg::*;

    logic [MANT_W-1:0]    m_reg  [FRAC_BITS];
    logic [FRAC_BITS-1:0] f_reg  [FRAC_BITS];
    logic [MANT_W-1:0]    m_next [FRAC_BITS];

    // stage k multiplies in factor k when fraction bit 15-k is set
    always_comb
    begin
        logic [2*MANT_W-1:0]  prod;
        logic [MANT_W-1:0]    m_prev;
        logic [FRAC_BITS-1:0] f_prev;
        for (int k = 0; k < FRAC_BITS; k++)
        begin
            m_prev = (k == 0) ? MANT_W'(1 << 30) : m_reg[(k == 0) ? 0 : k - 1];
            f_prev = (k == 0) ? frac : f_reg[(k == 0) ? 0 : k - 1];
            prod = {{MANT_W{1'b0}}, m_prev} * {{MANT_W{1'b0}}, POW2_ROM[k]};
            m_next[k] = f_prev[FRAC_BITS-1-k] ? prod[MANT_W+29:30] : m_prev;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < FRAC_BITS; k++)
            begin
                m_reg[k] <= m_next[k];
                f_reg[k] <= (k == 0) ? frac : f_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign mant = m_reg[FRAC_BITS-1];

endmodule

`default_nettype wire
